### rtl/hcfs_pkg.sv
// Shared types and constants of the hill-climb focus search block.
package hcfs_pkg;

    localparam int STEP_BITS = 17;
    localparam int SIDE_BITS = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] ACT_MOVE_REPORT = 2'd0;
    localparam logic [1:0] ACT_MOVE_ONLY = 2'd1;
    localparam logic [1:0] ACT_FINAL = 2'd2;

    localparam logic CFG_STEP_SIZE = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [1:0]           action;
        logic [SIDE_BITS-1:0] target_z;
        logic                 last;
    } result_t;

endpackage

### rtl/hcfs_pos_sat.sv
// Lens position plus signed step, saturated to the signed position range.
module hcfs_pos_sat #(
    parameter int POS_BITS = 32
) (
    input  logic signed [POS_BITS-1:0]          base_pos,
    input  logic signed [hcfs_pkg::STEP_BITS-1:0] offset,
    output logic signed [POS_BITS-1:0]          sat_pos
);

    localparam int SUM_BITS =
        (POS_BITS > hcfs_pkg::STEP_BITS ? POS_BITS : hcfs_pkg::STEP_BITS) + 1;

    logic signed [SUM_BITS-1:0] sum;
    logic                       fits;

    assign sum = SUM_BITS'(base_pos) + SUM_BITS'(offset);
    assign fits = (sum[SUM_BITS-1:POS_BITS-1] == '0) || (sum[SUM_BITS-1:POS_BITS-1] == '1);

    always_comb begin
        if (fits) begin
            sat_pos = sum[POS_BITS-1:0];
        end else if (sum[SUM_BITS-1]) begin
            sat_pos = {1'b1, {(POS_BITS-1){1'b0}}};
        end else begin
            sat_pos = {1'b0, {(POS_BITS-1){1'b1}}};
        end
    end

endmodule

### rtl/hill_climb_focus_search.sv
// Top level of the hill-climb autofocus sequencer.
// A beat passes the input register, then the result queue, on its way to m_tvalid.
// Throughput: one input beat per cycle while results are taken as they appear;
//   every beat waits in the input register until two result queue slots are free.
// Reset (aresetn low at a clock edge) empties the input register and result queue,
//   returns the sequencer to idle and restores step_size 1 and timeout_ticks 3999.
module hill_climb_focus_search #(
    parameter int POS_BITS = 32,
    parameter int SHARP_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // cfg_index: 0 step_size, 1 timeout_ticks
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] focus_value, [63:32] current_z
    input  logic [1:0]  s_tuser,  // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] target_z
    output logic [1:0]  m_tuser,  // [1:0] action
    output logic        m_tlast
);

    localparam int SB = hcfs_pkg::STEP_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PROBE_A,
        PH_HOME_A,
        PH_PROBE_B,
        PH_HOME_CLIMB,
        PH_CLIMB,
        PH_HOME_RESTART
    } phase_t;

    // configuration
    logic [15:0] step_size_reg;
    logic [31:0] timeout_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [31:0] f_raw_reg;
    logic [31:0] z_raw_reg;

    // sequencer state
    phase_t                       phase_reg, phase_next;
    logic signed [POS_BITS-1:0]   home_pos_reg, home_pos_next;
    logic [SHARP_BITS-1:0]        home_sharp_reg, home_sharp_next;
    logic [SHARP_BITS-1:0]        latest_sharp_reg, latest_sharp_next;
    logic signed [SB-1:0]         probe_step_reg, probe_step_next;
    logic signed [SB-1:0]         climb_step_reg, climb_step_next;
    logic [31:0]                  elapsed_reg, elapsed_next;
    logic                         in_final_reg, in_final_next;

    // result queue
    hcfs_pkg::result_t                  q_reg [hcfs_pkg::Q_DEPTH];
    logic [hcfs_pkg::Q_PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [hcfs_pkg::Q_CNT_BITS-1:0]    count_reg;

    logic                       commit;
    logic                       pop;
    logic [1:0]                 n_res;
    logic [63:0]                f_wide, z_wide;
    logic [SHARP_BITS-1:0]      f_cur;
    logic signed [POS_BITS-1:0] z_cur;
    logic signed [SB-1:0]       step_ext;
    logic signed [SB-1:0]       climb_abs_neg;
    logic signed [POS_BITS-1:0] base0;
    logic signed [SB-1:0]       off0;
    logic signed [POS_BITS-1:0] tgt0, tgt1;
    logic [63:0]                tgt0_wide, tgt1_wide;
    logic [1:0]                 act0;
    logic                       last0;
    logic                       res_go, res_any, g_pos, restart;
    logic                       probe_pos, climb_pos;
    hcfs_pkg::result_t          res0, res1;
    hcfs_pkg::result_t          head;

    assign cfg_ready = 1'b1;

    assign commit = in_valid_reg && (count_reg <= (hcfs_pkg::Q_CNT_BITS)'(hcfs_pkg::Q_DEPTH - 2));
    assign s_tready = !in_valid_reg || commit;
    assign pop = m_tvalid && m_tready;

    assign f_wide = {32'd0, f_raw_reg};
    assign z_wide = {32'd0, z_raw_reg};
    assign f_cur = f_wide[SHARP_BITS-1:0];
    assign z_cur = z_wide[POS_BITS-1:0];

    assign step_ext = {1'b0, step_size_reg};
    assign probe_pos = !probe_step_reg[SB-1] && (probe_step_reg != '0);
    assign climb_pos = !climb_step_reg[SB-1] && (climb_step_reg != '0);
    assign climb_abs_neg = climb_pos ? -climb_step_reg : climb_step_reg;

    hcfs_pos_sat #(.POS_BITS(POS_BITS)) u_sat_first (
        .base_pos (base0),
        .offset   (off0),
        .sat_pos  (tgt0)
    );

    hcfs_pos_sat #(.POS_BITS(POS_BITS)) u_sat_final (
        .base_pos (home_pos_reg),
        .offset   (climb_abs_neg),
        .sat_pos  (tgt1)
    );

    assign tgt0_wide = {{(64-POS_BITS){1'b0}}, tgt0};
    assign tgt1_wide = {{(64-POS_BITS){1'b0}}, tgt1};

    always_comb begin
        phase_next = phase_reg;
        home_pos_next = home_pos_reg;
        home_sharp_next = home_sharp_reg;
        latest_sharp_next = latest_sharp_reg;
        probe_step_next = probe_step_reg;
        climb_step_next = climb_step_reg;
        elapsed_next = elapsed_reg;
        in_final_next = in_final_reg;
        base0 = z_cur;
        off0 = '0;
        act0 = hcfs_pkg::ACT_MOVE_REPORT;
        last0 = 1'b1;
        n_res = 2'd0;
        res_go = 1'b0;
        res_any = 1'b0;
        g_pos = 1'b0;
        restart = 1'b0;

        if (commit) begin
            case (op_reg)
                hcfs_pkg::OP_TICK: begin
                    if (elapsed_reg != '1) begin
                        elapsed_next = elapsed_reg + 32'd1;
                    end
                end
                hcfs_pkg::OP_START: begin
                    if (phase_reg == PH_IDLE) begin
                        in_final_next = 1'b0;
                        home_pos_next = z_cur;
                        home_sharp_next = f_cur;
                        latest_sharp_next = f_cur;
                        probe_step_next = step_ext;
                        off0 = step_ext;
                        n_res = 2'd1;
                        phase_next = PH_PROBE_A;
                    end
                end
                hcfs_pkg::OP_MEASURE: begin
                    case (phase_reg)
                        PH_PROBE_A: begin
                            latest_sharp_next = f_cur;
                            if (f_cur > home_sharp_reg) begin
                                res_go = 1'b1;
                                res_any = 1'b1;
                                g_pos = probe_pos;
                            end else begin
                                base0 = home_pos_reg;
                                n_res = 2'd1;
                                phase_next = PH_HOME_A;
                            end
                        end
                        PH_HOME_A: begin
                            home_pos_next = z_cur;
                            home_sharp_next = f_cur;
                            latest_sharp_next = f_cur;
                            off0 = -probe_step_reg;
                            n_res = 2'd1;
                            phase_next = PH_PROBE_B;
                        end
                        PH_PROBE_B: begin
                            latest_sharp_next = f_cur;
                            res_go = 1'b1;
                            res_any = f_cur > home_sharp_reg;
                            g_pos = res_any && probe_step_reg[SB-1];
                        end
                        PH_HOME_CLIMB: begin
                            elapsed_next = '0;
                            latest_sharp_next = f_cur;
                            off0 = climb_step_reg;
                            n_res = 2'd1;
                            phase_next = PH_CLIMB;
                        end
                        PH_CLIMB: begin
                            latest_sharp_next = f_cur;
                            off0 = climb_step_reg;
                            n_res = 2'd1;
                            if ((elapsed_reg > timeout_reg) || !(f_cur > latest_sharp_reg)) begin
                                in_final_next = 1'b1;
                                probe_step_next = climb_step_reg;
                                home_pos_next = z_cur;
                                home_sharp_next = f_cur;
                                phase_next = PH_PROBE_A;
                            end
                        end
                        PH_HOME_RESTART: begin
                            in_final_next = 1'b0;
                            home_pos_next = z_cur;
                            home_sharp_next = f_cur;
                            latest_sharp_next = f_cur;
                            probe_step_next = step_ext;
                            off0 = step_ext;
                            n_res = 2'd1;
                            phase_next = PH_PROBE_A;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (res_go) begin
                base0 = home_pos_reg;
                off0 = '0;
                n_res = 2'd1;
                if (!in_final_reg) begin
                    if (!res_any) begin
                        act0 = hcfs_pkg::ACT_FINAL;
                        phase_next = PH_IDLE;
                    end else begin
                        climb_step_next = g_pos ? step_ext : -step_ext;
                        phase_next = PH_HOME_CLIMB;
                    end
                end else begin
                    restart = climb_pos ? g_pos : !g_pos;
                    in_final_next = 1'b0;
                    if (restart) begin
                        phase_next = PH_HOME_RESTART;
                    end else begin
                        act0 = hcfs_pkg::ACT_MOVE_ONLY;
                        last0 = 1'b0;
                        n_res = 2'd2;
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    always_comb begin
        res0.action = act0;
        res0.target_z = tgt0_wide[31:0];
        res0.last = last0;
        res1.action = hcfs_pkg::ACT_FINAL;
        res1.target_z = tgt1_wide[31:0];
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= 16'd1;
            timeout_reg <= 32'd3999;
            in_valid_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            home_pos_reg <= '0;
            home_sharp_reg <= '0;
            latest_sharp_reg <= '0;
            probe_step_reg <= '0;
            climb_step_reg <= '0;
            elapsed_reg <= '0;
            in_final_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hcfs_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_data[15:0];
                    hcfs_pkg::CFG_TIMEOUT:   timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg <= phase_next;
            home_pos_reg <= home_pos_next;
            home_sharp_reg <= home_sharp_next;
            latest_sharp_reg <= latest_sharp_next;
            probe_step_reg <= probe_step_next;
            climb_step_reg <= climb_step_next;
            elapsed_reg <= elapsed_next;
            in_final_reg <= in_final_next;
            wr_ptr_reg <= wr_ptr_reg + (hcfs_pkg::Q_PTR_BITS)'(n_res);
            rd_ptr_reg <= rd_ptr_reg + (hcfs_pkg::Q_PTR_BITS)'(pop);
            count_reg <= count_reg + (hcfs_pkg::Q_CNT_BITS)'(n_res)
                - (hcfs_pkg::Q_CNT_BITS)'(pop);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg <= s_tuser;
            f_raw_reg <= s_tdata[31:0];
            z_raw_reg <= s_tdata[63:32];
        end
        if (n_res != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            q_reg[wr_ptr_reg + (hcfs_pkg::Q_PTR_BITS)'(1)] <= res1;
        end
    end

    assign head = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata = head.target_z;
    assign m_tuser = head.action;
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (hcfs_pkg::Q_CNT_BITS)'(hcfs_pkg::Q_DEPTH))
        else $error("result queue overfilled");

    a_idle_not_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !in_final_reg)
        else $error("final check flag left set while idle");

    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (head.action == hcfs_pkg::ACT_FINAL)) |-> m_tlast)
        else $error("final move not marked last");

    a_start_probes: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (op_reg == hcfs_pkg::OP_START) && (phase_reg == PH_IDLE))
        |=> (phase_reg == PH_PROBE_A) && (count_reg != '0))
        else $error("start from idle did not issue first probe");
`endif

endmodule
